// File: src/twf_pkg.sv
package twf_pkg;

    localparam int DATA_W         = 16;
    localparam int HALF_W         = 17;
    localparam int ADDR_W         = 18;
    localparam int POS_W          = 19;
    localparam int RECIP_W        = 32;
    localparam int RCNT_W         = $clog2(RECIP_W);
    localparam int OUTS_PER_INPUT = 6;
    localparam int RUN_W          = $clog2(OUTS_PER_INPUT);
    localparam int RING_DEPTH     = 1 << ADDR_W;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(256);
    localparam logic [HALF_W-1:0] HALF_MIN   = HALF_W'(2);
    localparam logic [HALF_W-1:0] HALF_MAX   = HALF_W'(65536);

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic                recip_init;
        logic                recip_step;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic                issue;
        logic [ADDR_W-1:0]   rd_addr;
        logic [HALF_W-1:0]   k;
        logic                zero;
        logic                last;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_stat_t;

    function automatic logic [HALF_W-1:0] clamp_half(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        r = v;
        if (v < HALF_MIN)
        begin
            r = HALF_MIN;
        end
        else if (v > HALF_MAX)
        begin
            r = HALF_MAX;
        end
        return r;
    endfunction

endpackage

// File: src/twf_datapath.sv
module twf_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  twf_pkg::dp_cmd_t               cmd,
    output twf_pkg::dp_stat_t              stat,
    input  logic [twf_pkg::HALF_W-1:0]     half,
    input  logic [twf_pkg::DATA_W-1:0]     wr_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [twf_pkg::DATA_W-1:0]     out_data,
    output logic                           out_last
);
    import twf_pkg::*;

    logic [DATA_W-1:0] ring_mem [0:RING_DEPTH-1];

    // reciprocal unit: recip = floor(2^32 / half), one bit per step
    logic [15:0]        rem_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [16:0]        rem_sh;
    logic               rem_ge;

    // pipeline valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic out_valid_reg;

    // stage payloads
    logic [DATA_W-1:0] rd_data_reg;
    logic [HALF_W-1:0] k1_reg;
    logic              zero1_reg, zero2_reg, zero3_reg, zero4_reg, zero5_reg;
    logic              last1_reg, last2_reg, last3_reg, last4_reg, last5_reg;
    logic              neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [31:0]       prod1_reg, n3_reg, n4_reg, n5_reg;
    logic [63:0]       prod2_reg;
    logic [15:0]       q0_reg, q5_reg;
    logic [31:0]       qh_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [15:0] mag;
    logic [32:0] p1_full;
    logic [63:0] p2_full;
    logic [32:0] qh_full;
    logic [31:0] r_fix;
    logic [15:0] q_fix;
    logic [DATA_W-1:0] val;

    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = (rem_sh >= half);

    assign mag     = rd_data_reg[DATA_W-1] ? 16'(~rd_data_reg + 16'd1) : rd_data_reg;
    assign p1_full = 33'(mag) * 33'(k1_reg);
    assign p2_full = 64'(prod1_reg) * 64'(recip_reg);
    assign qh_full = 33'(q0_reg) * 33'(half);
    assign r_fix   = n5_reg - qh_reg;
    assign q_fix   = (r_fix >= 32'(half)) ? q5_reg + 16'd1 : q5_reg;
    assign val     = zero5_reg ? '0 : (neg5_reg ? 16'(~q_fix + 16'd1) : q_fix);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            ring_mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.issue && !cmd.zero)
        begin
            rd_data_reg <= ring_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.recip_init)
        begin
            rem_reg   <= 16'd1;
            recip_reg <= '0;
        end
        else if (cmd.recip_step)
        begin
            rem_reg   <= rem_ge ? 16'(rem_sh - 17'(half)) : rem_sh[15:0];
            recip_reg <= {recip_reg[RECIP_W-2:0], rem_ge};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        k1_reg    <= cmd.k;
        zero1_reg <= cmd.zero;
        last1_reg <= cmd.last;

        prod1_reg <= p1_full[31:0];
        neg2_reg  <= rd_data_reg[DATA_W-1];
        zero2_reg <= zero1_reg;
        last2_reg <= last1_reg;

        prod2_reg <= p2_full;
        n3_reg    <= prod1_reg;
        neg3_reg  <= neg2_reg;
        zero3_reg <= zero2_reg;
        last3_reg <= last2_reg;

        q0_reg    <= prod2_reg[47:32];
        n4_reg    <= n3_reg;
        neg4_reg  <= neg3_reg;
        zero4_reg <= zero3_reg;
        last4_reg <= last3_reg;

        qh_reg    <= qh_full[31:0];
        q5_reg    <= q0_reg;
        n5_reg    <= n4_reg;
        neg5_reg  <= neg4_reg;
        zero5_reg <= zero4_reg;
        last5_reg <= last4_reg;

        if (v5_reg)
        begin
            out_data_reg <= val;
            out_last_reg <= last5_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (v5_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    // one result in flight at a time
    a_single_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg}))
        else $error("more than one result in flight");

endmodule

// File: src/twf_ctrl.sv
module twf_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           restart,
    input  logic [twf_pkg::HALF_W-1:0]     half,
    input  logic                           in_valid,
    output logic                           in_ready,
    output twf_pkg::dp_cmd_t               cmd,
    input  twf_pkg::dp_stat_t              stat
);
    import twf_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_RECIP = 3'd1;
    localparam logic [2:0] S_IDLE  = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    logic [2:0]        state_reg,  state_next;
    logic [RCNT_W-1:0] rcnt_reg,   rcnt_next;
    logic [ADDR_W-1:0] wp_reg,     wp_next;
    logic [HALF_W-1:0] hop_reg,    hop_next;
    logic [POS_W-1:0]  emit_reg,   emit_next;
    logic [ADDR_W-1:0] fbase_reg,  fbase_next;
    logic              ready_reg,  ready_next;
    logic              primed_reg, primed_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [ADDR_W-1:0] rbase_reg,  rbase_next;
    logic [RUN_W-1:0]  j_reg,      j_next;

    logic              accept;
    logic [POS_W-1:0]  h_ext, h2_ext, six_h, emit_plus;
    logic [HALF_W-1:0] hop_plus;
    logic [ADDR_W-1:0] wp_plus;

    assign h_ext     = POS_W'(half);
    assign h2_ext    = h_ext << 1;
    assign six_h     = (h_ext << 2) + (h_ext << 1);
    assign emit_plus = emit_reg + POS_W'(OUTS_PER_INPUT);
    assign hop_plus  = hop_reg + HALF_W'(1);
    assign wp_plus   = wp_reg + ADDR_W'(1);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.recip_init = (state_reg == S_INIT);
        cmd.recip_step = (state_reg == S_RECIP);
        cmd.wr_en      = accept;
        cmd.wr_addr    = wp_reg;
        cmd.issue      = (state_reg == S_ISSUE);
        cmd.rd_addr    = rbase_reg + pos_reg[ADDR_W-1:0];
        cmd.zero       = (pos_reg >= h2_ext);
        cmd.k          = (pos_reg < h_ext) ? HALF_W'(pos_reg + POS_W'(1))
                                           : HALF_W'(h2_ext - POS_W'(1) - pos_reg);
        cmd.last       = (j_reg == RUN_W'(OUTS_PER_INPUT - 1));
    end

    always_comb
    begin
        state_next  = state_reg;
        rcnt_next   = rcnt_reg;
        wp_next     = wp_reg;
        hop_next    = hop_reg;
        emit_next   = emit_reg;
        fbase_next  = fbase_reg;
        ready_next  = ready_reg;
        primed_next = primed_reg;
        pos_next    = pos_reg;
        rbase_next  = rbase_reg;
        j_next      = j_reg;

        case (state_reg)
            S_INIT:
            begin
                rcnt_next  = '0;
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                rcnt_next = rcnt_reg + RCNT_W'(1);
                if (rcnt_reg == RCNT_W'(RECIP_W - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (ready_reg)
                    begin
                        pos_next   = emit_reg;
                        rbase_next = fbase_reg;
                        j_next     = '0;
                        state_next = S_ISSUE;
                        if (emit_plus >= six_h)
                        begin
                            emit_next  = '0;
                            ready_next = 1'b0;
                        end
                        else
                        begin
                            emit_next = emit_plus;
                        end
                    end
                    wp_next  = wp_plus;
                    hop_next = hop_plus;
                    if (hop_plus >= half)
                    begin
                        hop_next = '0;
                        if (primed_reg)
                        begin
                            fbase_next = wp_plus - ADDR_W'(h2_ext);
                            emit_next  = '0;
                            ready_next = 1'b1;
                        end
                        else
                        begin
                            primed_next = 1'b1;
                        end
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!stat.busy)
                begin
                    if (j_reg == RUN_W'(OUTS_PER_INPUT - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + RUN_W'(1);
                        pos_next   = pos_reg + POS_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (restart)
        begin
            state_next  = S_INIT;
            wp_next     = '0;
            hop_next    = '0;
            emit_next   = '0;
            fbase_next  = '0;
            ready_next  = 1'b0;
            primed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            rcnt_reg   <= '0;
            wp_reg     <= '0;
            hop_reg    <= '0;
            emit_reg   <= '0;
            fbase_reg  <= '0;
            ready_reg  <= 1'b0;
            primed_reg <= 1'b0;
            pos_reg    <= '0;
            rbase_reg  <= '0;
            j_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rcnt_reg   <= rcnt_next;
            wp_reg     <= wp_next;
            hop_reg    <= hop_next;
            emit_reg   <= emit_next;
            fbase_reg  <= fbase_next;
            ready_reg  <= ready_next;
            primed_reg <= primed_next;
            pos_reg    <= pos_next;
            rbase_reg  <= rbase_next;
            j_reg      <= j_next;
        end
    end

    a_issue_idle_dp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !stat.busy)
        else $error("issue while datapath busy");

    a_ready_needs_primed: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> primed_reg)
        else $error("window pending before first hop");

    a_hop_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hop_reg < half)
        else $error("hop count out of range");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg < six_h)
        else $error("emit position out of range");

endmodule

// File: src/triangular_window_framer_unit.sv
// Channel   | Dir | Signals                              | Contents
// s_axis    | in  | tvalid, tready, tdata[15:0]          | sample_in (signed)
// m_axis    | out | tvalid, tready, tdata[15:0], tlast   | sample_out (signed), last_of_run
// cfg       | in  | cfg_wr_en, cfg_wr_data[16:0]         | half_length (H, clamped to 2..65536)
//
// An input that arrives with no window pending is stored and s_axis_tready stays high.
// With a window pending, an input yields six results, one at a time through
// a 6-stage multiply/reciprocal pipeline; each result is issued only after the
// previous one has been taken, so m_axis_tready low holds the run back.
// After reset and after every half_length write, the reciprocal of H is built
// bit-serially; s_axis_tready stays low meanwhile.
// A half_length write restarts the framing and drops any pending window.
module triangular_window_framer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // [15:0] sample_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // [15:0] sample_out
    output logic                           m_axis_tlast,   // last_of_run
    input  logic                           cfg_wr_en,
    input  logic [twf_pkg::HALF_W-1:0]     cfg_wr_data     // half_length
);
    import twf_pkg::*;

    // effective (clamped) H
    logic [HALF_W-1:0] half_reg;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
        end
        else if (cfg_wr_en)
        begin
            half_reg <= clamp_half(cfg_wr_data);
        end
    end

    // sequencer: framing counters, window addressing, reciprocal stepping
    twf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_wr_en),
        .half     (half_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // sample ring, triangle shaping x*k/H, output register
    twf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .half      (half_reg),
        .wr_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
